// File: rtl/vsa_pkg.sv
// Shared types, register indexes, reset values and status codes of the steering advisory.
package vsa_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 17;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT   = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_QUAL  = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA     = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN      = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CORR  = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SUGG  = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_WIN_START = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_WIN_END   = 4'd7;

  // Register reset values
  localparam logic [15:0]        RST_TIMEOUT   = 16'd500;
  localparam logic [6:0]         RST_MIN_QUAL  = 7'd50;
  localparam logic [16:0]        RST_ALPHA     = 17'd32768;
  localparam logic signed [15:0] RST_GAIN      = 16'sd256;
  localparam logic [14:0]        RST_MAX_CORR  = 15'd4096;
  localparam logic [14:0]        RST_MAX_SUGG  = 15'd8192;
  localparam logic [15:0]        RST_WIN_START = 16'd0;
  localparam logic [15:0]        RST_WIN_END   = 16'd1000;

  localparam logic [16:0] ALPHA_ONE = 17'h10000;
  localparam logic [31:0] AGE_NONE  = 32'hFFFF_FFFF;

  // Status codes
  localparam logic [2:0] STATUS_WAIT_NAV = 3'd0;
  localparam logic [2:0] STATUS_WAIT_VIS = 3'd1;
  localparam logic [2:0] STATUS_STALE    = 3'd2;
  localparam logic [2:0] STATUS_UNCAL    = 3'd3;
  localparam logic [2:0] STATUS_OK       = 3'd4;

  typedef struct packed {
    logic [31:0]        frame_number;
    logic               vision_ok;
    logic               is_calibrated;
    logic               gap_found;
    logic [6:0]         gap_conf;
    logic signed [15:0] gap_error;
    logic signed [15:0] target_yaw_rate;
    logic [15:0]        distance_cm;
    logic               distance_ready;
    logic [31:0]        now_ms;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               steer_ok;
    logic signed [15:0] suggested_rate;
    logic signed [15:0] correction_rate;
    logic signed [15:0] filtered_error;
    logic [31:0]        visual_age;
    logic               vis_recent;
    logic               window_active;
    logic [31:0]        accepted_frames;
    logic [31:0]        rejected_frames;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  addr;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic load;   // capture the input request
    logic frame;  // frame detection and state update, filter product
    logic filt;   // filter update, age, freshness, window
    logic gain;   // status pick, gain product
    logic push;   // clamp and load the output register
  } vsa_cmd_t;

  typedef struct packed {
    logic out_free;
  } vsa_sts_t;

endpackage

// File: rtl/vsa_stream_if.sv
// Valid/ready channel carrying one payload of type T.
interface vsa_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/vsa_ctrl.sv
// Sequencer that steps one request through the datapath.
module vsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vsa_pkg::vsa_sts_t sts_i,
  output vsa_pkg::vsa_cmd_t cmd_o
);
  import vsa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRAME = 3'd1;
  localparam logic [2:0] S_FILT  = 3'd2;
  localparam logic [2:0] S_GAIN  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_FRAME;
      S_FRAME: state_d = S_FILT;
      S_FILT:  state_d = S_GAIN;
      S_GAIN:  state_d = S_OUT;
      S_OUT:   if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.frame = (state_q == S_FRAME);
  assign cmd_o.filt  = (state_q == S_FILT);
  assign cmd_o.gain  = (state_q == S_GAIN);
  assign cmd_o.push  = (state_q == S_OUT) && sts_i.out_free;

endmodule

// File: rtl/vsa_dpath.sv
// Datapath: registers, frame tracking, filter, status pick, clamps and output register.
module vsa_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vsa_pkg::vsa_cmd_t   cmd_i,
  output vsa_pkg::vsa_sts_t   sts_o,
  input  vsa_pkg::in_item_t   in_data_i,
  input  logic                cfg_we_i,
  input  vsa_pkg::cfg_wr_t    cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output vsa_pkg::out_item_t  out_data_o
);
  import vsa_pkg::*;

  function automatic logic signed [15:0] clamp_sym(input logic signed [20:0] v,
                                                   input logic [14:0] lim);
    logic signed [20:0] m;
    m = $signed({6'b0, lim});
    if (v < -m) begin
      clamp_sym = 16'(-m);
    end else if (v > m) begin
      clamp_sym = 16'(m);
    end else begin
      clamp_sym = v[15:0];
    end
  endfunction

  // Configuration registers
  logic [15:0]        timeout_q;
  logic [6:0]         min_qual_q;
  logic [16:0]        alpha_q;
  logic signed [15:0] gain_q;
  logic [14:0]        max_corr_q;
  logic [14:0]        max_sugg_q;
  logic [15:0]        win_start_q;
  logic [15:0]        win_end_q;

  // Tracking state
  logic               seen_q;
  logic [31:0]        last_frame_q;
  logic [31:0]        acc_q;
  logic [31:0]        rej_q;
  logic [31:0]        last_time_q;
  logic               cal_q;
  logic               obs_q;
  logic               primed_q;
  logic signed [15:0] fv_q;

  // Per-request working registers
  in_item_t           item_q;
  logic               mul_pend_q;
  logic signed [34:0] fprod_q;
  logic [31:0]        age_q;
  logic               fresh_q;
  logic               window_q;
  logic [2:0]         status_q;
  logic signed [31:0] gprod_q;
  logic               out_valid_q;
  out_item_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= RST_TIMEOUT;
      min_qual_q  <= RST_MIN_QUAL;
      alpha_q     <= RST_ALPHA;
      gain_q      <= RST_GAIN;
      max_corr_q  <= RST_MAX_CORR;
      max_sugg_q  <= RST_MAX_SUGG;
      win_start_q <= RST_WIN_START;
      win_end_q   <= RST_WIN_END;
    end else if (cfg_we_i) begin
      unique case (cfg_data_i.addr)
        CFG_TIMEOUT:   timeout_q   <= cfg_data_i.wdata[15:0];
        CFG_MIN_QUAL:  min_qual_q  <= cfg_data_i.wdata[6:0];
        CFG_ALPHA:     alpha_q     <= cfg_data_i.wdata;
        CFG_GAIN:      gain_q      <= $signed(cfg_data_i.wdata[15:0]);
        CFG_MAX_CORR:  max_corr_q  <= cfg_data_i.wdata[14:0];
        CFG_MAX_SUGG:  max_sugg_q  <= cfg_data_i.wdata[14:0];
        CFG_WIN_START: win_start_q <= cfg_data_i.wdata[15:0];
        CFG_WIN_END:   win_end_q   <= cfg_data_i.wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  // Frame step: restart clears the state seen by this request
  logic               seen_e, cal_e, obs_e, primed_e;
  logic [31:0]        last_e, acc_e, rej_e, time_e;
  logic signed [15:0] fv_e;
  logic               frame_chg, frame_acc, obs_new, upd;
  logic [16:0]        alpha_sat;
  logic signed [16:0] diff;

  always_comb begin
    seen_e    = item_q.restart ? 1'b0 : seen_q;
    last_e    = item_q.restart ? 32'd0 : last_frame_q;
    acc_e     = item_q.restart ? 32'd0 : acc_q;
    rej_e     = item_q.restart ? 32'd0 : rej_q;
    time_e    = item_q.restart ? 32'd0 : last_time_q;
    cal_e     = item_q.restart ? 1'b0 : cal_q;
    obs_e     = item_q.restart ? 1'b0 : obs_q;
    primed_e  = item_q.restart ? 1'b0 : primed_q;
    fv_e      = item_q.restart ? 16'sd0 : fv_q;
    frame_chg = !seen_e || (item_q.frame_number != last_e);
    frame_acc = frame_chg && item_q.vision_ok && (item_q.frame_number != 32'd0);
    obs_new   = item_q.gap_found && (item_q.gap_conf >= min_qual_q);
    upd       = frame_acc && obs_new;
    alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
    diff      = $signed({item_q.gap_error[15], item_q.gap_error})
              - $signed({fv_e[15], fv_e});
  end

  // Filter step, age, freshness and window
  logic signed [18:0] fstep;
  logic signed [18:0] fsum;
  logic               any_acc;
  logic [31:0]        age;
  logic               fresh;
  logic               window;

  always_comb begin
    fstep   = 19'((fprod_q + 35'sd32768) >>> 16);
    fsum    = $signed({{3{fv_q[15]}}, fv_q}) + fstep;
    any_acc = (acc_q != 32'd0);
    age     = any_acc ? (item_q.now_ms - last_time_q) : AGE_NONE;
    fresh   = any_acc && (age <= {16'd0, timeout_q});
    window  = item_q.distance_ready && (item_q.distance_cm >= win_start_q)
              && (item_q.distance_cm <= win_end_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_frame_q <= '0;
      acc_q        <= '0;
      rej_q        <= '0;
      last_time_q  <= '0;
      cal_q        <= 1'b0;
      obs_q        <= 1'b0;
      primed_q     <= 1'b0;
      fv_q         <= '0;
      mul_pend_q   <= 1'b0;
    end else if (cmd_i.frame) begin
      seen_q       <= 1'b1;
      last_frame_q <= item_q.frame_number;
      acc_q        <= acc_e + {31'd0, frame_acc};
      rej_q        <= rej_e + {31'd0, frame_chg && !frame_acc};
      last_time_q  <= frame_acc ? item_q.now_ms : time_e;
      cal_q        <= frame_acc ? item_q.is_calibrated : cal_e;
      obs_q        <= frame_acc ? obs_new : (frame_chg ? 1'b0 : obs_e);
      primed_q     <= upd ? 1'b1 : primed_e;
      fv_q         <= (upd && !primed_e) ? item_q.gap_error : fv_e;
      mul_pend_q   <= upd && primed_e;
    end else if (cmd_i.filt) begin
      if (mul_pend_q) begin
        fv_q <= fsum[15:0];
      end
      // stale vision drops the observation and re-primes the filter
      if (!fresh) begin
        obs_q    <= 1'b0;
        primed_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame) begin
      fprod_q <= diff * $signed({1'b0, alpha_sat});
    end
    if (cmd_i.filt) begin
      age_q    <= age;
      fresh_q  <= fresh;
      window_q <= window;
    end
    if (cmd_i.gain) begin
      gprod_q <= gain_q * fv_q;
    end
  end

  // Status pick
  logic [2:0] status;

  always_comb begin
    priority if (!window_q) begin
      status = STATUS_WAIT_NAV;
    end else if (acc_q == 32'd0) begin
      status = STATUS_WAIT_VIS;
    end else if (!fresh_q) begin
      status = STATUS_STALE;
    end else if (!cal_q) begin
      status = STATUS_UNCAL;
    end else if (!obs_q) begin
      status = STATUS_WAIT_VIS;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain) begin
      status_q <= status;
    end
  end

  // Output step
  logic               is_ok;
  logic signed [20:0] corr_raw;
  logic signed [15:0] corr;
  logic signed [20:0] sum;
  logic signed [15:0] sugg;

  always_comb begin
    is_ok    = (status_q == STATUS_OK);
    corr_raw = 21'((gprod_q + 32'sd1024) >>> 11);
    corr     = is_ok ? clamp_sym(corr_raw, max_corr_q) : 16'sd0;
    sum      = 21'(item_q.target_yaw_rate) + 21'(corr);
    sugg     = clamp_sym(sum, max_sugg_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.status          <= status_q;
      out_q.steer_ok        <= is_ok;
      out_q.suggested_rate  <= sugg;
      out_q.correction_rate <= corr;
      out_q.filtered_error  <= fv_q;
      out_q.visual_age      <= age_q;
      out_q.vis_recent      <= fresh_q;
      out_q.window_active   <= window_q;
      out_q.accepted_frames <= acc_q;
      out_q.rejected_frames <= rej_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// File: rtl/visual_steering_advisory.sv
// Each accepted request steps through the fixed controller sequence of capture,
// frame update with filter multiply, filter add, gain multiply and clamp; the next request
// is accepted only after the result is pushed, and the push waits for a free output register.
// A finished result waits in the output register while the next request is accepted.
// Reset restores all configuration registers to defaults and clears all tracking state.
// A request with restart set clears tracking state before it is processed.
module visual_steering_advisory (
  input  logic         clk_i,
  input  logic         rst_ni,
  vsa_stream_if.sink   in_i,
  vsa_stream_if.source out_o,
  vsa_stream_if.sink   cfg_i
);
  import vsa_pkg::*;

  vsa_cmd_t cmd;
  vsa_sts_t sts;

  assign cfg_i.ready = 1'b1;

  vsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vsa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.frame, cmd.filt, cmd.gain, cmd.push}))
    else $error("more than one datapath command active");

  a_accept_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cmd.frame)
    else $error("accepted request not followed by frame step");

  a_frame_filt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.frame |=> cmd.filt)
    else $error("frame step not followed by filter step");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.out_free)
    else $error("result pushed over an unread result");

  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> out_o.valid)
    else $error("pushed result not presented");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the visual steering advisory block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vsa_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 9;
  localparam int PHASE_TICKS   = 125;

  logic clk;
  logic rst_n;

  vsa_stream_if #(.T(in_item_t))  tick_if ();
  vsa_stream_if #(.T(out_item_t)) adv_if ();
  vsa_stream_if #(.T(cfg_wr_t))   cfg_if ();

  visual_steering_advisory uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if),
    .out_o  (adv_if),
    .cfg_i  (cfg_if)
  );

  // Register copies
  logic [15:0]        timeout_ms;
  logic [6:0]         min_qual;
  logic [16:0]        alpha;
  logic signed [15:0] gain;
  logic [14:0]        corr_lim;
  logic [14:0]        sugg_lim;
  logic [15:0]        win_start;
  logic [15:0]        win_end;

  // Tracking state copies
  logic               src_seen;
  logic [31:0]        prev_frame;
  logic [31:0]        n_accepted;
  logic [31:0]        n_rejected;
  logic [31:0]        t_last_accept;
  logic               cal_seen;
  logic               obs_ok;
  logic               primed;
  logic signed [15:0] filt_err;

  in_item_t  pending_ticks[$];
  out_item_t expected_advisories[$];
  out_item_t want_adv;

  int   failures = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  bit   hold_flip = 1'b0;
  bit   hold_seen = 1'b0;
  logic tick_taken = 1'b0;

  logic [31:0] mission_frame;
  logic [31:0] mission_now;

  function automatic void clear_tracking();
    src_seen      = 1'b0;
    prev_frame    = '0;
    n_accepted    = '0;
    n_rejected    = '0;
    t_last_accept = '0;
    cal_seen      = 1'b0;
    obs_ok        = 1'b0;
    primed        = 1'b0;
    filt_err      = '0;
  endfunction

  function automatic void reset_registers();
    timeout_ms = RST_TIMEOUT;
    min_qual   = RST_MIN_QUAL;
    alpha      = RST_ALPHA;
    gain       = RST_GAIN;
    corr_lim   = RST_MAX_CORR;
    sugg_lim   = RST_MAX_SUGG;
    win_start  = RST_WIN_START;
    win_end    = RST_WIN_END;
    clear_tracking();
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] addr, logic [CfgDataW-1:0] wdata);
    case (addr)
      CFG_TIMEOUT:   timeout_ms = wdata[15:0];
      CFG_MIN_QUAL:  min_qual   = wdata[6:0];
      CFG_ALPHA:     alpha      = wdata;
      CFG_GAIN:      gain       = wdata[15:0];
      CFG_MAX_CORR:  corr_lim   = wdata[14:0];
      CFG_MAX_SUGG:  sugg_lim   = wdata[14:0];
      CFG_WIN_START: win_start  = wdata[15:0];
      CFG_WIN_END:   win_end    = wdata[15:0];
      default: ;
    endcase
  endfunction

  // Divide by 2^s, halves round toward +infinity
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_mag(longint v, logic [14:0] lim);
    longint m;
    m = longint'(lim);
    if (v < -m) return -m;
    if (v > m) return m;
    return v;
  endfunction

  function automatic out_item_t predict_advisory(in_item_t t);
    out_item_t   o;
    logic        win;
    logic        fresh;
    logic        any;
    logic [31:0] age;
    logic [16:0] a;
    logic [2:0]  st;
    longint      d;
    longint      corr;
    longint      sugg;
    if (t.restart) clear_tracking();
    win = t.distance_ready && t.distance_cm >= win_start && t.distance_cm <= win_end;
    if (!src_seen || t.frame_number != prev_frame) begin
      src_seen   = 1'b1;
      prev_frame = t.frame_number;
      if (t.vision_ok && t.frame_number != '0) begin
        n_accepted    = n_accepted + 1;
        t_last_accept = t.now_ms;
        cal_seen      = t.is_calibrated;
        obs_ok        = t.gap_found && t.gap_conf >= min_qual;
        if (obs_ok) begin
          if (!primed) begin
            filt_err = t.gap_error;
            primed   = 1'b1;
          end else begin
            a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
            d = longint'(t.gap_error) - longint'(filt_err);
            filt_err = 16'(longint'(filt_err) + round_half_up(d * longint'(a), 16));
          end
        end
      end else begin
        n_rejected = n_rejected + 1;
        obs_ok     = 1'b0;
      end
    end

    any = n_accepted != '0;
    if (any) begin
      age   = t.now_ms - t_last_accept;
      fresh = age <= {16'd0, timeout_ms};
    end else begin
      age   = AGE_NONE;
      fresh = 1'b0;
    end
    if (!fresh) begin
      obs_ok = 1'b0;
      primed = 1'b0;
    end

    if (!win) st = STATUS_WAIT_NAV;
    else if (!any) st = STATUS_WAIT_VIS;
    else if (!fresh) st = STATUS_STALE;
    else if (!cal_seen) st = STATUS_UNCAL;
    else if (!obs_ok) st = STATUS_WAIT_VIS;
    else st = STATUS_OK;

    corr = 0;
    if (st == STATUS_OK) begin
      corr = clamp_mag(round_half_up(longint'(gain) * longint'(filt_err), 11), corr_lim);
      sugg = clamp_mag(longint'(t.target_yaw_rate) + corr, sugg_lim);
    end else begin
      sugg = clamp_mag(longint'(t.target_yaw_rate), sugg_lim);
    end

    o.status          = st;
    o.steer_ok        = (st == STATUS_OK);
    o.suggested_rate  = 16'(sugg);
    o.correction_rate = 16'(corr);
    o.filtered_error  = filt_err;
    o.visual_age      = age;
    o.vis_recent      = fresh;
    o.window_active   = win;
    o.accepted_frames = n_accepted;
    o.rejected_frames = n_rejected;
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Request driver: offer the head of the queue, drop it once taken
  always @(negedge clk) begin
    if (tick_taken) void'(pending_ticks.pop_front());
    if (rst_n && (!tick_if.valid || tick_taken)) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_if.valid <= 1'b1;
        tick_if.data  <= pending_ticks[0];
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_flip != hold_seen) begin
      hold_seen    <= hold_flip;
      hold_left    <= HOLD_CYCLES;
      adv_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      adv_if.ready <= 1'b0;
    end else begin
      adv_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tick_taken <= rst_n && tick_if.valid && tick_if.ready;
    if (rst_n && cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.data.addr, cfg_if.data.wdata);
    if (rst_n && tick_if.valid && tick_if.ready) begin
      expected_advisories.push_back(predict_advisory(tick_if.data));
    end
    if (rst_n && adv_if.valid && adv_if.ready) begin
      if (expected_advisories.size() == 0) begin
        $error("advisory with no pending request");
        failures++;
      end else begin
        want_adv = expected_advisories.pop_front();
        check_field("status", want_adv.status, adv_if.data.status);
        check_field("steer_ok", want_adv.steer_ok, adv_if.data.steer_ok);
        check_field("suggested_rate", want_adv.suggested_rate, adv_if.data.suggested_rate);
        check_field("correction_rate", want_adv.correction_rate, adv_if.data.correction_rate);
        check_field("filtered_error", want_adv.filtered_error, adv_if.data.filtered_error);
        check_field("visual_age", want_adv.visual_age, adv_if.data.visual_age);
        check_field("vis_recent", want_adv.vis_recent, adv_if.data.vis_recent);
        check_field("window_active", want_adv.window_active, adv_if.data.window_active);
        check_field("accepted_frames", want_adv.accepted_frames, adv_if.data.accepted_frames);
        check_field("rejected_frames", want_adv.rejected_frames, adv_if.data.rejected_frames);
      end
    end
  end

  // Watchdog: give up when no channel moves for too long
  always @(posedge clk) begin
    if ((tick_if.valid && tick_if.ready) || (adv_if.valid && adv_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{addr: idx, wdata: value};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [16:0] tmo, mq, al, gn, mc, ms, ws, we);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_MIN_QUAL, mq);
    write_reg(CFG_ALPHA, al);
    write_reg(CFG_GAIN, gn);
    write_reg(CFG_MAX_CORR, mc);
    write_reg(CFG_MAX_SUGG, ms);
    write_reg(CFG_WIN_START, ws);
    write_reg(CFG_WIN_END, we);
  endtask

  task automatic await_idle();
    while (pending_ticks.size() != 0 || expected_advisories.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void push_tick(logic [31:0] frame, bit vok, bit cal, bit gap,
                                    logic [6:0] q, logic signed [15:0] err,
                                    logic signed [15:0] tgt, logic [15:0] dist_cm,
                                    bit dready, logic [31:0] now, bit rs);
    in_item_t t;
    t.frame_number    = frame;
    t.vision_ok       = vok;
    t.is_calibrated   = cal;
    t.gap_found       = gap;
    t.gap_conf        = q;
    t.gap_error       = err;
    t.target_yaw_rate = tgt;
    t.distance_cm     = dist_cm;
    t.distance_ready  = dready;
    t.now_ms          = now;
    t.restart         = rs;
    pending_ticks.push_back(t);
  endfunction

  // Mostly a coherent mission (advancing frames and time), some raw noise
  task automatic gen_ticks(int n);
    in_item_t     t;
    logic [127:0] raw;
    int           k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        t = in_item_t'(raw[$bits(in_item_t)-1:0]);
      end else begin
        if ($urandom_range(99) < 85) mission_frame += $urandom_range(3, 1);
        if ($urandom_range(99) < 2) mission_frame = '0;
        mission_now += $urandom_range(timeout_ms / 8 + 1);
        if ($urandom_range(99) < 5) mission_now += $urandom_range(2 * timeout_ms + 2);
        t.frame_number    = mission_frame;
        t.vision_ok       = $urandom_range(99) < 95;
        t.is_calibrated   = $urandom_range(99) < 92;
        t.gap_found       = $urandom_range(99) < 90;
        t.gap_conf        = ($urandom_range(99) < 85) ? 7'($urandom_range(127, min_qual))
                                                      : 7'($urandom);
        t.gap_error       = 16'($urandom);
        t.target_yaw_rate = ($urandom_range(1) == 0) ? 16'($urandom)
                                                     : 16'(int'($urandom_range(8000)) - 4000);
        t.distance_cm     = ($urandom_range(99) < 85) ? 16'($urandom_range(win_end, win_start))
                                                      : 16'($urandom);
        t.distance_ready  = $urandom_range(99) < 95;
        t.now_ms          = mission_now;
        t.restart         = $urandom_range(99) < 3;
      end
      pending_ticks.push_back(t);
    end
  endtask

  task automatic setup_phase(int ph);
    case (ph)
      0: write_all(17'd0, 17'd0, 17'd0, 17'h08000, 17'd32767, 17'd32767, 17'd0, 17'd65535);
      1: write_all(17'd65535, 17'd100, 17'h1FFFF, 17'd32767, 17'd0, 17'd1, 17'd0, 17'd65535);
      2: write_all(17'd1, 17'd127, 17'h10000, 17'd1, 17'd1, 17'd32767, 17'd1000, 17'd1000);
      3: write_all(17'(RST_TIMEOUT), 17'(RST_MIN_QUAL), RST_ALPHA, 17'(RST_GAIN),
                   17'(RST_MAX_CORR), 17'(RST_MAX_SUGG), 17'(RST_WIN_START),
                   17'(RST_WIN_END));
      4: write_all(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                   17'($urandom), 17'd5000, 17'd4999);
      default: write_all(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                         17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
    endcase
    case (ph)
      1, 6: begin
        send_idle_pct  = 87;
        recv_stall_pct = 0;
      end
      2, 7: begin
        send_idle_pct  = 0;
        recv_stall_pct = 87;
      end
      4, 8: begin
        send_idle_pct  = 13;
        recv_stall_pct = 13;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    int ph;
    rst_n         = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.data  = '0;
    adv_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    reset_registers();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks on the reset configuration
    push_tick(32'd0, 1, 1, 1, 100, 0, 0, 500, 0, 100, 0);
    push_tick(32'd1, 0, 1, 1, 100, 0, 0, 500, 1, 105, 0);
    push_tick(32'd2, 1, 1, 1, 100, 32767, -32768, 0, 1, 110, 0);
    push_tick(32'd2, 1, 1, 1, 100, 0, 100, 10, 1, 200, 0);
    push_tick(32'd3, 1, 1, 1, 127, -32768, 32767, 1000, 1, 210, 0);
    push_tick(32'd4, 1, 1, 1, 49, 1000, 0, 1001, 1, 220, 0);
    push_tick(32'd5, 1, 0, 1, 50, 1000, 0, 20, 1, 230, 0);
    push_tick(32'd6, 1, 1, 0, 90, 1000, 0, 20, 1, 240, 0);
    // same frame one ms past the timeout: stale
    push_tick(32'd6, 1, 1, 1, 90, 1000, 0, 20, 1, 741, 0);
    push_tick(32'd7, 1, 1, 1, 80, -5, 300, 20, 1, 750, 0);
    push_tick(32'd7, 1, 1, 1, 80, 0, 300, 20, 1, 1250, 0);
    push_tick(32'd7, 1, 1, 1, 80, 2000, 300, 20, 1, 1260, 1);
    // time wraps between these two
    push_tick(32'd8, 1, 1, 1, 80, 2000, -300, 20, 1, 32'hFFFF_FFF0, 0);
    push_tick(32'd8, 1, 1, 1, 80, 0, -300, 20, 1, 32'h10, 0);
    push_tick(32'd9, 1, 1, 1, 60, 4000, 0, 16'hFFFF, 1, 32'h20, 0);
    push_tick(32'hFFFF_FFFF, 1, 1, 1, 60, 1, 1, 30, 1, 32'h30, 0);
    push_tick(32'd0, 1, 1, 1, 60, 1, 1, 30, 1, 32'h40, 0);
    push_tick(32'd10, 0, 1, 1, 60, 1, 1, 30, 1, 32'h50, 0);
    await_idle();

    mission_frame = $urandom;
    mission_now   = $urandom;
    for (ph = 0; ph < PHASES; ph++) begin
      setup_phase(ph);
      gen_ticks(PHASE_TICKS);
      if (ph == 3) hold_flip = ~hold_flip;
      await_idle();
    end

    if (failures == 0 && expected_advisories.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
